// ----- rtl/core/postfix_expression_evaluator_macros.svh -----
// Assertion macros for the postfix evaluator RTL.
// Used by modules that check their own control logic; expects clk and rst_n in scope.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pfx_pkg.sv -----
// Shared constants, types and codes of the postfix evaluator.
// No dependencies; imported by every module of the block except pfx_ram.
`timescale 1ns / 1ps

package pfx_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 48;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 48;

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);

  // multiplier: magnitudes split in two halves, one half-by-half product per cycle
  localparam int HALF_W = (VALUE_WIDTH + 1) / 2;
  localparam int MAG_W  = 2 * HALF_W;
  localparam int PROD_W = 4 * HALF_W;
  // divider: numerator is the left magnitude shifted up by the fraction bits
  localparam int NUM_W  = VALUE_WIDTH + FRAC_BITS;
  localparam int WIDE_W = (PROD_W > NUM_W) ? PROD_W : NUM_W;
  localparam int CNT_W  = ($clog2(NUM_W) > 3) ? $clog2(NUM_W) : 3;

  // letter position is 5 bits
  localparam int POS_W  = 5;
  localparam int LVX_W  = POS_W + FRAC_BITS + VALUE_WIDTH;

  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  localparam logic [7:0] CH_LC_BASE   = 8'd96;
  localparam logic [7:0] CH_UC_BASE   = 8'd64;
  localparam logic [7:0] LETTER_COUNT = 8'd26;
  localparam logic [7:0] CH_PLUS      = 8'd43;
  localparam logic [7:0] CH_MINUS     = 8'd45;
  localparam logic [7:0] CH_STAR      = 8'd42;
  localparam logic [7:0] CH_SLASH     = 8'd47;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic under;
    logic over;
    logic divz;
    logic bad;
    logic sat;
  } err_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic divz;
  } alu_rsp_t;

endpackage

// ----- rtl/core/pfx_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pfx_alu.sv -----
// Multi-cycle fixed-point arithmetic unit: saturating add/sub, split multiplier,
// restoring divider. Depends on pfx_pkg.
`timescale 1ns / 1ps

module pfx_alu
  import pfx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  alu_req_t               req,
  input  logic [VALUE_WIDTH-1:0] left,
  input  logic [VALUE_WIDTH-1:0] right,
  output alu_rsp_t               rsp,
  output logic [VALUE_WIDTH-1:0] result
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_PREP,
    A_MUL,
    A_DIV,
    A_FIN,
    A_DONE
  } alu_state_t;

  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(4);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);

  alu_state_t state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [VALUE_WIDTH-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [VALUE_WIDTH-1:0] res_r, res_nxt;
  logic               sat_r, sat_nxt, divz_r, divz_nxt, neg_r, neg_nxt;
  logic [MAG_W-1:0]   ma_r, ma_nxt, mb_r, mb_nxt;
  logic [MAG_W-1:0]   pp_r, pp_nxt;
  logic [1:0]         pidx_r, pidx_nxt;
  logic [PROD_W-1:0]  acc_r, acc_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt, quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // operand split into sign and magnitude
  logic                   na, nb;
  logic [VALUE_WIDTH-1:0] a_neg, b_neg, ma, mb;
  logic [VALUE_WIDTH:0]   sum;
  logic [HALF_W-1:0]      a_half, b_half;
  logic [PROD_W-1:0]      pp_sh;
  logic [VALUE_WIDTH:0]   rem_sh, rem_diff;
  logic                   q_bit;
  logic [WIDE_W-1:0]      mag_w, lim_w, pick_w;
  logic                   fin_sat;
  logic [VALUE_WIDTH-1:0] fin_val;

  always_comb begin
    na    = a_r[VALUE_WIDTH-1];
    nb    = b_r[VALUE_WIDTH-1];
    a_neg = -a_r;
    b_neg = -b_r;
    ma    = na ? a_neg : a_r;
    mb    = nb ? b_neg : b_r;
    if (op_r == OP_SUB) begin
      sum = {a_r[VALUE_WIDTH-1], a_r} - {b_r[VALUE_WIDTH-1], b_r};
    end else begin
      sum = {a_r[VALUE_WIDTH-1], a_r} + {b_r[VALUE_WIDTH-1], b_r};
    end

    a_half = cnt_r[1] ? ma_r[MAG_W-1:HALF_W] : ma_r[HALF_W-1:0];
    b_half = cnt_r[0] ? mb_r[MAG_W-1:HALF_W] : mb_r[HALF_W-1:0];
    case (pidx_r)
      2'd0:    pp_sh = PROD_W'(pp_r);
      2'd3:    pp_sh = PROD_W'(pp_r) << (2 * HALF_W);
      default: pp_sh = PROD_W'(pp_r) << HALF_W;
    endcase

    rem_sh   = {rem_r, num_r[NUM_W-1]};
    q_bit    = rem_sh >= {1'b0, mb_r[VALUE_WIDTH-1:0]};
    rem_diff = rem_sh - {1'b0, mb_r[VALUE_WIDTH-1:0]};

    if (op_r == OP_MUL) begin
      mag_w = WIDE_W'(acc_r >> FRAC_BITS);
    end else begin
      mag_w = WIDE_W'(quo_r);
    end
    // negative side reaches one further than the positive side
    lim_w   = (WIDE_W'(1) << (VALUE_WIDTH - 1)) - WIDE_W'(!neg_r);
    fin_sat = mag_w > lim_w;
    pick_w  = fin_sat ? lim_w : mag_w;
    fin_val = pick_w[VALUE_WIDTH-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    sat_nxt   = sat_r;
    divz_nxt  = divz_r;
    neg_nxt   = neg_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    pp_nxt    = pp_r;
    pidx_nxt  = pidx_r;
    acc_nxt   = acc_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt    = req.op;
          a_nxt     = left;
          b_nxt     = right;
          state_nxt = A_PREP;
        end
      end
      A_PREP: begin
        sat_nxt  = 1'b0;
        divz_nxt = 1'b0;
        ma_nxt   = MAG_W'(ma);
        mb_nxt   = MAG_W'(mb);
        neg_nxt  = na ^ nb;
        cnt_nxt  = '0;
        acc_nxt  = '0;
        rem_nxt  = '0;
        quo_nxt  = '0;
        num_nxt  = NUM_W'(ma) << FRAC_BITS;
        case (op_r)
          OP_ADD, OP_SUB: begin
            if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) begin
              sat_nxt = 1'b1;
              res_nxt = sum[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
            end else begin
              res_nxt = sum[VALUE_WIDTH-1:0];
            end
            state_nxt = A_DONE;
          end
          OP_MUL: begin
            state_nxt = A_MUL;
          end
          default: begin
            if (mb == '0) begin
              // sign of the left operand picks the bound
              divz_nxt  = 1'b1;
              res_nxt   = na ? VAL_MIN : VAL_MAX;
              state_nxt = A_DONE;
            end else begin
              state_nxt = A_DIV;
            end
          end
        endcase
      end
      A_MUL: begin
        if (cnt_r < MUL_STEPS) begin
          pp_nxt   = MAG_W'(a_half) * MAG_W'(b_half);
          pidx_nxt = cnt_r[1:0];
        end
        if (cnt_r != '0) begin
          acc_nxt = acc_r + pp_sh;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == MUL_STEPS) begin
          state_nxt = A_FIN;
        end
      end
      A_DIV: begin
        rem_nxt = q_bit ? rem_diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], q_bit};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = A_FIN;
        end
      end
      A_FIN: begin
        sat_nxt   = fin_sat;
        res_nxt   = neg_r ? -fin_val : fin_val;
        state_nxt = A_DONE;
      end
      A_DONE: begin
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    sat_r  <= sat_nxt;
    divz_r <= divz_nxt;
    neg_r  <= neg_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    pp_r   <= pp_nxt;
    pidx_r <= pidx_nxt;
    acc_r  <= acc_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done = (state_r == A_DONE);
  assign rsp.sat  = sat_r;
  assign rsp.divz = divz_r;
  assign result   = res_r;

endmodule

// ----- rtl/core/postfix_expression_evaluator.sv -----
// Postfix expression evaluator: a letter pushes its alphabet position as a
// signed fixed-point value (16 fraction bits, 48-bit word) onto a 64-entry
// operand stack kept in a synchronous RAM; + - * / pop two values and push
// the saturated result. The token flagged last yields one request on the
// result channel carrying the value of the last operation (0 if none) and
// the sticky error flags, after which the stack and flags are cleared.
// Per token: a letter, a bad character or an operator short of operands is
// taken in S_IDLE; an operator passes S_IDLE, S_RD_L and S_START for the
// two stack reads and ALU start, then waits in S_WAIT while the ALU steps
// A_PREP, A_DONE for + and -, or A_PREP, A_MUL or A_DIV, A_FIN, A_DONE for
// * and / (one quotient bit per cycle over 64 numerator bits, restoring
// divider). A last token loads the output register in S_EMIT, waiting there
// until it is taken. Tokens are handled one at a time; the output register
// lets a new expression start while the previous result is still waiting.
// Depends on pfx_pkg, pfx_ram and pfx_alu.
`timescale 1ns / 1ps
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator
  import pfx_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_token_char,
  input  logic                    in_is_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_result_value,
  output logic                    out_underflow_flag,
  output logic                    out_overflow_flag,
  output logic                    out_div_zero_flag,
  output logic                    out_bad_char_flag,
  output logic                    out_saturate_flag
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_L,
    S_START,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [SP_W-1:0]               sp_r, sp_nxt;
  logic signed [VALUE_WIDTH-1:0] last_result_r, last_result_nxt;
  err_t                          err_r, err_nxt;
  op_t                           op_r, op_nxt;
  logic                          last_r, last_nxt;
  logic [VALUE_WIDTH-1:0]        right_r, right_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]       out_value_r, out_value_nxt;
  err_t                          out_err_r, out_err_nxt;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;
  logic [VALUE_WIDTH-1:0] alu_result;

  logic                   is_letter, is_op;
  op_t                    tok_op;
  logic [LVX_W-1:0]       lv_wide;
  logic                   lv_sat;
  logic [VALUE_WIDTH-1:0] letter_val;
  logic [SP_W-1:0]        sp_m1, sp_m2;

  pfx_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfx_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .left   (ram_rdata),
    .right  (right_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // token decode; low five bits of a letter are its alphabet position
  always_comb begin
    is_letter = (in_token_char inside {[CH_LC_BASE + 8'd1 : CH_LC_BASE + LETTER_COUNT],
                                       [CH_UC_BASE + 8'd1 : CH_UC_BASE + LETTER_COUNT]});
    is_op     = (in_token_char inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH});
    case (in_token_char)
      CH_PLUS:  tok_op = OP_ADD;
      CH_MINUS: tok_op = OP_SUB;
      CH_STAR:  tok_op = OP_MUL;
      default:  tok_op = OP_DIV;
    endcase
    lv_wide    = LVX_W'(in_token_char[POS_W-1:0]) << FRAC_BITS;
    lv_sat     = |lv_wide[LVX_W-1:VALUE_WIDTH-1];
    letter_val = lv_sat ? VAL_MAX : lv_wide[VALUE_WIDTH-1:0];
    sp_m1      = sp_r - SP_W'(1);
    sp_m2      = sp_r - SP_W'(2);
  end

  always_comb begin
    state_nxt       = state_r;
    sp_nxt          = sp_r;
    last_result_nxt = last_result_r;
    err_nxt         = err_r;
    op_nxt          = op_r;
    last_nxt        = last_r;
    right_nxt       = right_r;
    out_valid_nxt   = out_valid_r;
    out_value_nxt   = out_value_r;
    out_err_nxt     = out_err_r;
    ram_we          = 1'b0;
    ram_waddr       = sp_r[ADDR_W-1:0];
    ram_wdata       = letter_val;
    ram_raddr       = sp_m1[ADDR_W-1:0];
    alu_req.start   = 1'b0;
    alu_req.op      = op_r;
    in_ready        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt  = in_is_last;
          state_nxt = in_is_last ? S_EMIT : S_IDLE;
          if (is_letter) begin
            if (sp_r == SP_W'(STACK_DEPTH)) begin
              err_nxt.over = 1'b1;
            end else begin
              ram_we      = 1'b1;
              sp_nxt      = sp_r + SP_W'(1);
              err_nxt.sat = err_r.sat | lv_sat;
            end
          end else if (is_op) begin
            if (sp_r < SP_W'(2)) begin
              err_nxt.under = 1'b1;
            end else begin
              // read of the right operand is issued this cycle
              op_nxt    = tok_op;
              state_nxt = S_RD_L;
            end
          end else begin
            err_nxt.bad = 1'b1;
          end
        end
      end
      S_RD_L: begin
        right_nxt = ram_rdata;
        ram_raddr = sp_m2[ADDR_W-1:0];
        state_nxt = S_START;
      end
      S_START: begin
        // left operand arrives on the RAM read port this cycle
        alu_req.start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          ram_we          = 1'b1;
          ram_waddr       = sp_m2[ADDR_W-1:0];
          ram_wdata       = alu_result;
          sp_nxt          = sp_m1;
          last_result_nxt = alu_result;
          err_nxt.sat     = err_r.sat | alu_rsp.sat;
          err_nxt.divz    = err_r.divz | alu_rsp.divz;
          state_nxt       = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_value_nxt   = OUT_W'(last_result_r);
          out_err_nxt     = err_r;
          sp_nxt          = '0;
          last_result_nxt = '0;
          err_nxt         = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sp_r          <= '0;
      last_result_r <= '0;
      err_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sp_r          <= sp_nxt;
      last_result_r <= last_result_nxt;
      err_r         <= err_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    last_r      <= last_nxt;
    right_r     <= right_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_value_r;
  assign out_underflow_flag = out_err_r.under;
  assign out_overflow_flag  = out_err_r.over;
  assign out_div_zero_flag  = out_err_r.divz;
  assign out_bad_char_flag  = out_err_r.bad;
  assign out_saturate_flag  = out_err_r.sat;

  `PFX_ASSERT_SAME(a_sp_range, 1'b1, sp_r <= SP_W'(STACK_DEPTH), "stack pointer past depth")
  `PFX_ASSERT_SAME(a_alu_done_wait, alu_rsp.done, state_r == S_WAIT, "ALU done outside wait")
  `PFX_ASSERT_SAME(a_ram_we_state, ram_we, state_r == S_IDLE || state_r == S_WAIT,
                   "stack write in wrong state")
  `PFX_ASSERT_NEXT(a_emit_clears, state_r == S_EMIT && (!out_valid_r || out_ready),
                   sp_r == '0 && last_result_r == '0 && err_r == '0 && out_valid_r,
                   "expression state not cleared on emit")

endmodule

// ----- tb/sv/postfix_expression_evaluator_tb.sv -----
// Testbench for postfix_expression_evaluator: directed and random token streams
// checked against a fixed-point stack predictor kept in a scoreboard class.
// Depends on pfx_pkg and the postfix_expression_evaluator RTL.
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb
  import pfx_pkg::*;
();

  localparam int unsigned TOKEN_TARGET = 1050;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    err_t                    flags;
  } eval_result_t;

  class postfix_scoreboard;
    logic [VALUE_WIDTH-1:0] operands [STACK_DEPTH];
    int unsigned            depth;
    logic [VALUE_WIDTH-1:0] last_value;
    err_t                   sticky;
    eval_result_t           pending_results[$];
    int unsigned            mismatches;

    function new();
      depth      = 0;
      last_value = '0;
      sticky     = '0;
      mismatches = 0;
    endfunction

    function logic signed [127:0] widen(logic [VALUE_WIDTH-1:0] v);
      return {{(128 - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
    endfunction

    // clamp a sign/magnitude pair to the value range
    function logic [VALUE_WIDTH-1:0] saturate(bit neg, logic [127:0] mag);
      logic [127:0] lim;
      lim = 128'(1) << (VALUE_WIDTH - 1);
      if (!neg) lim = lim - 1;
      if (mag > lim) begin
        sticky.sat = 1'b1;
        mag = lim;
      end
      return neg ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
    endfunction

    function logic [VALUE_WIDTH-1:0] combine(logic [7:0] ch, logic [VALUE_WIDTH-1:0] lhs,
                                             logic [VALUE_WIDTH-1:0] rhs);
      logic signed [127:0] wl, wr, sum;
      logic [127:0]        ml, mr;
      bit                  nl, nr;
      wl = widen(lhs);
      wr = widen(rhs);
      nl = (wl < 0);
      nr = (wr < 0);
      ml = nl ? -wl : wl;
      mr = nr ? -wr : wr;
      if (ch == CH_PLUS || ch == CH_MINUS) begin
        sum = (ch == CH_PLUS) ? wl + wr : wl - wr;
        return saturate(sum < 0, (sum < 0) ? -sum : sum);
      end
      if (ch == CH_STAR) return saturate(nl ^ nr, (ml * mr) >> FRAC_BITS);
      // divide by zero pins to a bound by the left sign, no saturate flag
      if (mr == 0) begin
        sticky.divz = 1'b1;
        return nl ? VAL_MIN : VAL_MAX;
      end
      return saturate(nl ^ nr, (ml << FRAC_BITS) / mr);
    endfunction

    function void note_token(logic [7:0] ch, bit last);
      logic [7:0]          pos;
      logic signed [127:0] wide;
      eval_result_t        res;
      pos = '0;
      if (ch > CH_LC_BASE && ch <= CH_LC_BASE + LETTER_COUNT) pos = ch - CH_LC_BASE;
      else if (ch > CH_UC_BASE && ch <= CH_UC_BASE + LETTER_COUNT) pos = ch - CH_UC_BASE;
      if (pos != 0) begin
        if (depth >= STACK_DEPTH) begin
          sticky.over = 1'b1;
        end else begin
          operands[depth] = saturate(1'b0, 128'(pos) << FRAC_BITS);
          depth++;
        end
      end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
        if (depth < 2) begin
          sticky.under = 1'b1;
        end else begin
          last_value = combine(ch, operands[depth-2], operands[depth-1]);
          depth--;
          operands[depth-1] = last_value;
        end
      end else begin
        sticky.bad = 1'b1;
      end
      if (last) begin
        wide = widen(last_value);
        res.value = wide[OUT_W-1:0];
        res.flags = sticky;
        pending_results.insert(pending_results.size(), res);
        depth      = 0;
        last_value = '0;
        sticky     = '0;
      end
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(eval_result_t got);
      eval_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: value %0d", got.value);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      check_field("result_value", want.value, got.value);
      check_field("underflow_flag", want.flags.under, got.flags.under);
      check_field("overflow_flag", want.flags.over, got.flags.over);
      check_field("div_zero_flag", want.flags.divz, got.flags.divz);
      check_field("bad_char_flag", want.flags.bad, got.flags.bad);
      check_field("saturate_flag", want.flags.sat, got.flags.sat);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_token_char = '0;
  logic                    in_is_last = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_result_value;
  logic                    out_underflow_flag;
  logic                    out_overflow_flag;
  logic                    out_div_zero_flag;
  logic                    out_bad_char_flag;
  logic                    out_saturate_flag;

  postfix_scoreboard sb = new();
  logic [7:0]        tokens[$];
  int unsigned       sent_tokens = 0;
  int unsigned       results_seen = 0;
  int unsigned       quiet_cycles = 0;
  bit                in_burst = 1'b0;
  bit                out_burst = 1'b0;

  always #4 clk = ~clk;

  postfix_expression_evaluator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_token_char      (in_token_char),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_value   (out_result_value),
    .out_underflow_flag (out_underflow_flag),
    .out_overflow_flag  (out_overflow_flag),
    .out_div_zero_flag  (out_div_zero_flag),
    .out_bad_char_flag  (out_bad_char_flag),
    .out_saturate_flag  (out_saturate_flag)
  );

  // valid stays up across back-to-back requests; this task lowers it only for a gap
  task automatic send_token(input logic [7:0] ch, input bit last);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_token_char <= ch;
    in_is_last    <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_token(ch, last);
    sent_tokens++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_token(s[i], i == s.len() - 1);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic append_token(input logic [7:0] ch);
    tokens.insert(tokens.size(), ch);
  endtask

  function automatic logic [7:0] rand_letter(int unsigned lo, int unsigned hi);
    logic [7:0] pos;
    pos = 8'($urandom_range(lo, hi));
    return ($urandom_range(0, 1) ? CH_LC_BASE : CH_UC_BASE) + pos;
  endfunction

  function automatic logic [7:0] rand_operator(bit mul_heavy);
    if (mul_heavy && $urandom_range(0, 3) != 0) return CH_STAR;
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic make_expression();
    int unsigned kind, pushes, ops, depth, lo_pos, hi_pos;
    bit          mul_heavy;
    tokens.delete();
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      // run the stack to near full, and often to full and past it
      repeat ($urandom_range(62, 67)) append_token(rand_letter(1, 26));
      repeat ($urandom_range(1, 4)) append_token(rand_operator(1'b0));
    end else if (kind < 12) begin
      repeat ($urandom_range(1, 8)) append_token(8'($urandom_range(0, 255)));
    end else begin
      mul_heavy = ($urandom_range(0, 5) == 0);
      pushes    = mul_heavy ? $urandom_range(6, 12) : $urandom_range(1, 8);
      lo_pos    = mul_heavy ? 20 : 1;
      // narrow alphabet makes equal operands, hence zero divisors, common
      hi_pos    = (!mul_heavy && $urandom_range(0, 2) == 0) ? 3 : 26;
      ops       = pushes - 1;
      depth     = 0;
      while (pushes + ops != 0) begin
        if (depth >= 2 && ops != 0 && (pushes == 0 || $urandom_range(0, 1))) begin
          append_token(rand_operator(mul_heavy));
          ops--;
          depth--;
        end else begin
          append_token(rand_letter(lo_pos, hi_pos));
          pushes--;
          depth++;
        end
      end
      if ($urandom_range(0, 6) == 0)
        tokens[$urandom_range(0, tokens.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0) tokens.push_front(rand_operator(1'b0));
    end
  endtask

  initial begin
    logic [7:0] odd_chars [6];
    odd_chars = '{CH_UC_BASE, CH_UC_BASE + LETTER_COUNT + 8'd1, CH_LC_BASE,
                  CH_LC_BASE + LETTER_COUNT + 8'd1, 8'h00, 8'hFF};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_text("a+");
    send_text("ab-");
    foreach (odd_chars[i]) send_token(odd_chars[i], 1'b0);
    send_text("aa-/");
    send_text("BAa-/");
    send_text("aZ-z*z*z*z*z*z*");
    wait_results_drained();

    while (sent_tokens < TOKEN_TARGET) begin
      in_burst = ($urandom_range(0, 3) == 0);
      make_expression();
      foreach (tokens[i]) send_token(tokens[i], i == tokens.size() - 1);
      if ($urandom_range(0, 49) == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid && out_ready));
      results_seen++;
      if (results_seen % 8 == 0) out_burst = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{value: out_result_value,
                        flags: '{under: out_underflow_flag, over: out_overflow_flag,
                                 divz: out_div_zero_flag, bad: out_bad_char_flag,
                                 sat: out_saturate_flag}});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
